// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define KTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kts assertion failed");
// next-cycle implication
`define KTS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kts assertion failed");
`endif

// ===== rtl/core/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and saturation helpers of the centroid tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package kts_pkg;

   localparam int FRAC_BITS_DEF  = 8;
   localparam int COORD_BITS_DEF = 12;

   localparam int SV_BITS      = 24;
   localparam int SUM_BITS     = 42;
   localparam int COV_BITS     = 40;
   localparam int COV_SUM_BITS = 43;
   localparam int CFG_BITS     = 16;
   localparam int LIMIT_BITS   = 4;
   localparam int CSR_ADDR_W   = 8;
   localparam int RSP_DATA_W   = 4 * SV_BITS;

   localparam logic signed [SV_BITS-1:0] SV_MAX_S = {1'b0, {(SV_BITS-1){1'b1}}};
   localparam logic signed [SV_BITS-1:0] SV_MIN_S = {1'b1, {(SV_BITS-1){1'b0}}};
   localparam logic [COV_BITS-1:0]       COV_MAX  = '1;

   // result mode codes
   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_ARMED  = 2'd1;
   localparam logic [1:0] MODE_TRACK  = 2'd2;
   localparam logic [1:0] MODE_LOST   = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PROCESS_NOISE = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MEASURE_NOISE = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INITIAL_COV   = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MISS_LIMIT    = 8'd3;

   localparam logic [CFG_BITS-1:0]   NOISE_RESET = 16'd25;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd3;
   localparam logic [LIMIT_BITS-1:0] MISS_SAT    = '1;

   typedef enum logic [2:0] {
      OP_P_INNOV,
      OP_C_INNOV,
      OP_C_C,
      OP_P_R,
      OP_C_R
   } md_op_type;

   typedef struct packed {
      logic      load;
      logic      simple;
      logic      predict;
      logic      setup;
      logic      md_start;
      logic      md_store;
      logic      commit;
      logic      finish;
      logic      axis;
      md_op_type op;
   } kts_cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       found;
      logic       s_zero;
      logic       md_done;
   } kts_status_type;

   function automatic logic signed [SV_BITS-1:0] sat_sv(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi_lim;
      logic signed [SUM_BITS-1:0] lo_lim;
      hi_lim = SUM_BITS'(SV_MAX_S);
      lo_lim = SUM_BITS'(SV_MIN_S);
      if (v > hi_lim)      return SV_MAX_S;
      else if (v < lo_lim) return SV_MIN_S;
      else                 return v[SV_BITS-1:0];
   endfunction

   function automatic logic [COV_BITS-1:0] sat_cov(input logic [COV_SUM_BITS-1:0] v);
      return (v > COV_SUM_BITS'(COV_MAX)) ? COV_MAX : v[COV_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kts_muldiv.sv =====
// ----------------------------------------------------------------------------
// kts_muldiv
// Bit-serial floor(a*b/d): shift-add multiply then restoring divide,
// quotient saturated to the covariance range.
// ----------------------------------------------------------------------------
`default_nettype none
module kts_muldiv
   import kts_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [COV_BITS-1:0] a,
   input  wire logic [COV_BITS-1:0] b,
   input  wire logic [COV_BITS:0]   d,
   output logic                     done,
   output logic [COV_BITS-1:0]      q
);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   localparam logic [6:0] MUL_LAST = 7'(COV_BITS - 1);
   localparam logic [6:0] DIV_LAST = 7'(2 * COV_BITS - 1);
   localparam logic [6:0] Q_LOW    = 7'(COV_BITS);

   md_state_type          state_ff, state_in;
   logic                  done_ff, done_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [COV_BITS-1:0]   a_ff, a_in;
   logic [COV_BITS:0]     d_ff, d_in;
   logic [COV_BITS-1:0]   hi_ff, hi_in;
   logic [COV_BITS-1:0]   lo_ff, lo_in;
   logic [COV_BITS+1:0]   rem_ff, rem_in;
   logic [COV_BITS-1:0]   q_ff, q_in;
   logic                  over_ff, over_in;

   logic [COV_BITS:0]     add;
   logic [COV_BITS+1:0]   rem_sh;
   logic                  ge;

   always_comb begin
      add    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      rem_sh = {rem_ff[COV_BITS:0], hi_ff[COV_BITS-1]};
      ge     = rem_sh >= {1'b0, d_ff};

      state_in = state_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      over_in  = over_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               a_in     = a;
               d_in     = d;
               hi_in    = '0;
               lo_in    = b;
               rem_in   = '0;
               q_in     = '0;
               over_in  = 1'b0;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            hi_in  = add[COV_BITS:1];
            lo_in  = {add[0], lo_ff[COV_BITS-1:1]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            // product shifts out msb first into the remainder
            {hi_in, lo_in} = {hi_ff[COV_BITS-2:0], lo_ff, 1'b0};
            rem_in  = ge ? rem_sh - {1'b0, d_ff} : rem_sh;
            q_in    = {q_ff[COV_BITS-2:0], ge};
            over_in = over_ff | (ge & (cnt_ff < Q_LOW));
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      d_ff    <= d_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      over_ff <= over_in;
   end

   assign done = done_ff;
   assign q    = over_ff ? COV_MAX : q_ff;

endmodule
`default_nettype wire

// ===== rtl/core/kts_ctrl.sv =====
// ----------------------------------------------------------------------------
// kts_ctrl
// Frame sequencer: dispatch by track mode, per-axis correction through the
// shared multiply-divide unit, result register handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module kts_ctrl
   import kts_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire kts_status_type  status,
   output kts_cmd_type          cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_SETUP, S_CHECK, S_MDGO, S_MDWAIT, S_COMMIT, S_FINISH
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           axis_ff, axis_in;
   md_op_type      op_ff, op_in;
   logic           valid_ff, valid_in;
   logic           slot_free;
   logic           emit;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      op_in    = op_ff;
      emit     = 1'b0;
      cmd      = '0;
      cmd.axis = axis_ff;
      cmd.op   = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.mode == MODE_TRACK) begin
               cmd.predict = 1'b1;
               axis_in     = 1'b0;
               state_in    = status.found ? S_SETUP : S_FINISH;
            end else if (slot_free) begin
               cmd.simple = 1'b1;
               emit       = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            // zero innovation variance skips this axis
            if (status.s_zero) begin
               axis_in  = 1'b1;
               state_in = axis_ff ? S_FINISH : S_SETUP;
            end else begin
               op_in    = OP_P_INNOV;
               state_in = S_MDGO;
            end
         end
         S_MDGO: begin
            cmd.md_start = 1'b1;
            state_in     = S_MDWAIT;
         end
         S_MDWAIT: begin
            if (status.md_done) begin
               cmd.md_store = 1'b1;
               state_in     = S_MDGO;
               unique case (op_ff)
                  OP_P_INNOV: op_in = OP_C_INNOV;
                  OP_C_INNOV: op_in = OP_C_C;
                  OP_C_C:     op_in = OP_P_R;
                  OP_P_R:     op_in = OP_C_R;
                  default:    state_in = S_COMMIT;
               endcase
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            axis_in    = 1'b1;
            state_in   = axis_ff ? S_FINISH : S_SETUP;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               emit       = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff  <= 1'b0;
         op_ff    <= OP_P_INNOV;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         op_ff    <= op_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/core/kts_datapath.sv =====
// ----------------------------------------------------------------------------
// kts_datapath
// Track state, covariance, configuration registers, predict and correct
// arithmetic around the shared multiply-divide unit, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module kts_datapath
   import kts_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_write,
   input  wire logic [CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [CFG_BITS-1:0]     csr_data,
   input  wire logic                    found,
   input  wire logic [COORD_BITS-1:0]   box_left,
   input  wire logic [COORD_BITS-1:0]   box_top,
   input  wire logic [COORD_BITS-1:0]   box_right,
   input  wire logic [COORD_BITS-1:0]   box_bottom,
   input  wire kts_cmd_type             cmd,
   output kts_status_type               status,
   output logic [1:0]                   mode,
   output logic signed [SV_BITS-1:0]    pred_x,
   output logic signed [SV_BITS-1:0]    pred_y,
   output logic signed [SV_BITS-1:0]    post_x,
   output logic signed [SV_BITS-1:0]    post_y
);

   localparam int ZW = COORD_BITS + FRAC_BITS;

   // configuration
   logic [CFG_BITS-1:0]   qcfg_ff, qcfg_in, rcfg_ff, rcfg_in, pcfg_ff, pcfg_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   // track state
   logic [1:0]                  mode_ff, mode_in;
   logic [LIMIT_BITS-1:0]       miss_ff, miss_in;
   logic signed [SV_BITS-1:0]   prev_ff [2], prev_in [2];
   logic signed [SV_BITS-1:0]   pos_ff [2], pos_in [2];
   logic signed [SV_BITS-1:0]   vel_ff [2], vel_in [2];
   logic [COV_BITS-1:0]         pcov_ff [2], pcov_in [2];
   logic [COV_BITS-1:0]         ccov_ff [2], ccov_in [2];
   logic [COV_BITS-1:0]         vcov_ff [2], vcov_in [2];

   // per-frame working registers
   logic                        found_ff, found_in;
   logic signed [SV_BITS-1:0]   z_ff [2], z_in [2];
   logic signed [SV_BITS-1:0]   pred_ff [2], pred_in [2];
   logic [COV_BITS:0]           s_ff, s_in;
   logic [SV_BITS:0]            mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic [COV_BITS-1:0]         tmp_ff [5], tmp_in [5];

   // result register
   logic [1:0]                  omode_ff, omode_in;
   logic signed [SV_BITS-1:0]   opred_ff [2], opred_in [2];
   logic signed [SV_BITS-1:0]   opost_ff [2], opost_in [2];

   logic [COORD_BITS:0]         csum [2];
   logic [ZW-1:0]               cwide [2];
   logic signed [SV_BITS-1:0]   cent [2];
   logic [COV_BITS-1:0]         qn, rn, p0;
   logic signed [SV_BITS-1:0]   pos_pred [2];
   logic [COV_BITS-1:0]         p_pred [2], c_pred [2], v_pred [2];
   logic signed [SV_BITS:0]     innov;
   logic signed [SUM_BITS-1:0]  dpos, dvel;
   logic [LIMIT_BITS-1:0]       miss_next;
   logic                        lost;
   logic [COV_BITS-1:0]         md_a, md_b;
   logic                        md_done;
   logic [COV_BITS-1:0]         md_q;

   assign csum[0] = (COORD_BITS+1)'(box_left) + (COORD_BITS+1)'(box_right);
   assign csum[1] = (COORD_BITS+1)'(box_top) + (COORD_BITS+1)'(box_bottom);

   assign qn = COV_BITS'(qcfg_ff) << FRAC_BITS;
   assign rn = COV_BITS'(rcfg_ff) << FRAC_BITS;
   assign p0 = COV_BITS'(pcfg_ff) << FRAC_BITS;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         // centroid = edge sum / 2 in fixed point
         cwide[k] = ZW'(csum[k]) << (FRAC_BITS - 1);
         cent[k]  = (33'(cwide[k]) > 33'(SV_MAX_S)) ? SV_MAX_S : SV_BITS'(cwide[k]);
         pos_pred[k] = sat_sv(SUM_BITS'(pos_ff[k]) + SUM_BITS'(vel_ff[k]));
         p_pred[k] = sat_cov(COV_SUM_BITS'(pcov_ff[k]) + (COV_SUM_BITS'(ccov_ff[k]) << 1)
                             + COV_SUM_BITS'(vcov_ff[k]) + COV_SUM_BITS'(qn));
         c_pred[k] = sat_cov(COV_SUM_BITS'(ccov_ff[k]) + COV_SUM_BITS'(vcov_ff[k]));
         v_pred[k] = sat_cov(COV_SUM_BITS'(vcov_ff[k]) + COV_SUM_BITS'(qn));
      end
   end

   assign innov = (SV_BITS+1)'(z_ff[cmd.axis]) - (SV_BITS+1)'(pos_ff[cmd.axis]);

   always_comb begin
      dpos = neg_ff ? -$signed({2'b00, tmp_ff[0]}) : $signed({2'b00, tmp_ff[0]});
      dvel = neg_ff ? -$signed({2'b00, tmp_ff[1]}) : $signed({2'b00, tmp_ff[1]});
   end

   assign miss_next = found_ff ? '0 : ((miss_ff == MISS_SAT) ? MISS_SAT : miss_ff + 4'd1);
   assign lost      = miss_next >= limit_ff;

   always_comb begin
      case (cmd.op)
         OP_P_INNOV: begin md_a = pcov_ff[cmd.axis]; md_b = COV_BITS'(mag_ff); end
         OP_C_INNOV: begin md_a = ccov_ff[cmd.axis]; md_b = COV_BITS'(mag_ff); end
         OP_C_C:     begin md_a = ccov_ff[cmd.axis]; md_b = ccov_ff[cmd.axis]; end
         OP_P_R:     begin md_a = pcov_ff[cmd.axis]; md_b = rn; end
         default:    begin md_a = ccov_ff[cmd.axis]; md_b = rn; end
      endcase
   end

   kts_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (s_ff),
      .done  (md_done),
      .q     (md_q)
   );

   always_comb begin
      qcfg_in  = qcfg_ff;
      rcfg_in  = rcfg_ff;
      pcfg_in  = pcfg_ff;
      limit_in = limit_ff;
      if (csr_write) begin
         unique case (csr_addr)
            CSR_PROCESS_NOISE: qcfg_in  = csr_data;
            CSR_MEASURE_NOISE: rcfg_in  = csr_data;
            CSR_INITIAL_COV:   pcfg_in  = csr_data;
            CSR_MISS_LIMIT:    limit_in = csr_data[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      miss_in  = miss_ff;
      prev_in  = prev_ff;
      pos_in   = pos_ff;
      vel_in   = vel_ff;
      pcov_in  = pcov_ff;
      ccov_in  = ccov_ff;
      vcov_in  = vcov_ff;
      found_in = found_ff;
      z_in     = z_ff;
      pred_in  = pred_ff;
      s_in     = s_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      tmp_in   = tmp_ff;
      omode_in = omode_ff;
      opred_in = opred_ff;
      opost_in = opost_ff;

      if (cmd.load) begin
         found_in = found;
         z_in     = cent;
      end

      if (cmd.simple) begin
         opred_in[0] = '0;
         opred_in[1] = '0;
         opost_in[0] = '0;
         opost_in[1] = '0;
         if (mode_ff == MODE_ARMED) begin
            if (found_ff) begin
               // track start: velocity from the stored centroid
               for (int k = 0; k < 2; k++) begin
                  pos_in[k]   = z_ff[k];
                  vel_in[k]   = sat_sv(SUM_BITS'(z_ff[k]) - SUM_BITS'(prev_ff[k]));
                  pcov_in[k]  = p0;
                  ccov_in[k]  = '0;
                  vcov_in[k]  = p0;
                  opred_in[k] = z_ff[k];
                  opost_in[k] = z_ff[k];
               end
               miss_in  = '0;
               mode_in  = MODE_TRACK;
               omode_in = MODE_TRACK;
            end else begin
               mode_in  = MODE_SEARCH;
               omode_in = MODE_SEARCH;
            end
         end else if (found_ff) begin
            prev_in  = z_ff;
            mode_in  = MODE_ARMED;
            omode_in = MODE_ARMED;
         end else begin
            mode_in  = MODE_SEARCH;
            omode_in = MODE_SEARCH;
         end
      end

      if (cmd.predict) begin
         pos_in  = pos_pred;
         pred_in = pos_pred;
         pcov_in = p_pred;
         ccov_in = c_pred;
         vcov_in = v_pred;
      end

      if (cmd.setup) begin
         s_in   = (COV_BITS+1)'(pcov_ff[cmd.axis]) + (COV_BITS+1)'(rn);
         neg_in = innov[SV_BITS];
         mag_in = innov[SV_BITS] ? (SV_BITS+1)'(-innov) : (SV_BITS+1)'(innov);
      end

      if (cmd.md_store) begin
         tmp_in[3'(cmd.op)] = md_q;
      end

      if (cmd.commit) begin
         pos_in[cmd.axis]  = sat_sv(SUM_BITS'(pos_ff[cmd.axis]) + dpos);
         vel_in[cmd.axis]  = sat_sv(SUM_BITS'(vel_ff[cmd.axis]) + dvel);
         pcov_in[cmd.axis] = tmp_ff[3];
         ccov_in[cmd.axis] = tmp_ff[4];
         vcov_in[cmd.axis] = (vcov_ff[cmd.axis] > tmp_ff[2]) ?
                             vcov_ff[cmd.axis] - tmp_ff[2] : '0;
      end

      if (cmd.finish) begin
         opred_in = pred_ff;
         opost_in = pos_ff;
         if (lost) begin
            mode_in  = MODE_SEARCH;
            miss_in  = '0;
            omode_in = MODE_LOST;
         end else begin
            miss_in  = miss_next;
            omode_in = MODE_TRACK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qcfg_ff  <= NOISE_RESET;
         rcfg_ff  <= NOISE_RESET;
         pcfg_ff  <= NOISE_RESET;
         limit_ff <= LIMIT_RESET;
         mode_ff  <= MODE_SEARCH;
         miss_ff  <= '0;
         for (int k = 0; k < 2; k++) begin
            prev_ff[k] <= '0;
            pos_ff[k]  <= '0;
            vel_ff[k]  <= '0;
            pcov_ff[k] <= '0;
            ccov_ff[k] <= '0;
            vcov_ff[k] <= '0;
         end
      end else begin
         qcfg_ff  <= qcfg_in;
         rcfg_ff  <= rcfg_in;
         pcfg_ff  <= pcfg_in;
         limit_ff <= limit_in;
         mode_ff  <= mode_in;
         miss_ff  <= miss_in;
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
         pcov_ff  <= pcov_in;
         ccov_ff  <= ccov_in;
         vcov_ff  <= vcov_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      z_ff     <= z_in;
      pred_ff  <= pred_in;
      s_ff     <= s_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      tmp_ff   <= tmp_in;
      omode_ff <= omode_in;
      opred_ff <= opred_in;
      opost_ff <= opost_in;
   end

   assign status.mode    = mode_ff;
   assign status.found   = found_ff;
   assign status.s_zero  = (s_ff == '0);
   assign status.md_done = md_done;

   assign mode   = omode_ff;
   assign pred_x = opred_ff[0];
   assign pred_y = opred_ff[1];
   assign post_x = opost_ff[0];
   assign post_y = opost_ff[1];

endmodule
`default_nettype wire

// ===== rtl/core/kalman_track_step_core.sv =====
// a search or armed frame writes its result from the dispatch state; a tracking
// frame without a box predicts and finishes; with a box each axis of nonzero
// innovation variance runs five operations on the shared bit-serial
// multiply-divide unit. one frame at a time: the next transfer is taken the
// cycle after the result is written. synchronous active-high reset
// resets mode, miss count, track state and registers (noise 25, limit 3); no sweep.
// ----------------------------------------------------------------------------
// kalman_track_step_core
// Two-axis constant-velocity centroid tracker with search/armed/track modes.
// ----------------------------------------------------------------------------
`default_nettype none
module kalman_track_step_core
   import kts_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // box_left, box_top, box_right, box_bottom
   input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]      req_tdata,
   // found
   input  wire logic [0:0]                             req_tuser,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // pred_x, pred_y, post_x, post_y
   output logic [RSP_DATA_W-1:0]                       rsp_tdata,
   // mode
   output logic [1:0]                                  rsp_tuser,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [CSR_ADDR_W-1:0]                  csr_addr,
   input  wire logic [CFG_BITS-1:0]                    csr_data
);

   kts_cmd_type               cmd;
   kts_status_type            status;
   logic signed [SV_BITS-1:0] pred_x, pred_y, post_x, post_y;

   assign csr_ready = 1'b1;

   kts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kts_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_data   (csr_data),
      .found      (req_tuser[0]),
      .box_left   (req_tdata[COORD_BITS-1:0]),
      .box_top    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .box_right  (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .box_bottom (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .cmd        (cmd),
      .status     (status),
      .mode       (rsp_tuser),
      .pred_x     (pred_x),
      .pred_y     (pred_y),
      .post_x     (post_x),
      .post_y     (post_y)
   );

   assign rsp_tdata = {post_y, post_x, pred_y, pred_x};

endmodule
`default_nettype wire

// ===== rtl/core/kts_checker.sv =====
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks on the tracker core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module kts_checker
   import kts_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   // no result survives reset
   `KTS_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_tvalid)
   // a stalled result holds
   `KTS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one frame in flight: busy right after a transfer
   `KTS_ASSERT_NXT(a_one_frame, clock, reset, req_tvalid && req_tready, !req_tready)
   // no track means zero estimates
   `KTS_ASSERT_IMP(a_idle_zero, clock, reset, rsp_tvalid && (rsp_tuser == MODE_SEARCH || rsp_tuser == MODE_ARMED), rsp_tdata == '0)

endmodule

bind kalman_track_step_core kts_checker u_kts_checker (.*);
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives frame items into the centroid tracker under random bursts, output
// stalls and register settings, predicts every result in a scoreboard and
// compares mode and the four position fields of each result.
// ----------------------------------------------------------------------------
`default_nettype none

import kts_pkg::*;

class track_scoreboard;

   typedef struct {
      logic [1:0]  mode;
      logic [23:0] px, py, qx, qy;
   } frame_result_type;

   logic [15:0]      q_noise, r_noise, p_init;
   logic [3:0]       miss_lim;
   logic [1:0]       trk_mode;
   longint           prev_cen[2];
   longint           st[4];
   logic [63:0]      cov_p[2], cov_c[2], cov_v[2];
   int unsigned      misses;
   int               fails;
   frame_result_type pending[$];

   function new();
      q_noise  = NOISE_RESET;
      r_noise  = NOISE_RESET;
      p_init   = NOISE_RESET;
      miss_lim = LIMIT_RESET;
      trk_mode = MODE_SEARCH;
      misses   = 0;
      fails    = 0;
      for (int k = 0; k < 2; k++) begin
         prev_cen[k] = 0;
         cov_p[k] = 0;
         cov_c[k] = 0;
         cov_v[k] = 0;
      end
      for (int k = 0; k < 4; k++) st[k] = 0;
   endfunction

   function void write_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
         CSR_PROCESS_NOISE: q_noise  = val;
         CSR_MEASURE_NOISE: r_noise  = val;
         CSR_INITIAL_COV:   p_init   = val;
         CSR_MISS_LIMIT:    miss_lim = val[3:0];
         default: ;
      endcase
   endfunction

   function longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function logic [63:0] clip_cov(logic [63:0] v);
      return (v > 64'(COV_MAX)) ? 64'(COV_MAX) : v;
   endfunction

   // exact product, truncated quotient, saturated at the covariance ceiling
   function logic [63:0] scaled_ratio(logic [63:0] a, logic [63:0] b, logic [63:0] d);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = 128'(a) * 128'(b);
      quo  = prod / 128'(d);
      return (quo > 128'(COV_MAX)) ? 64'(COV_MAX) : quo[63:0];
   endfunction

   function void predict_axis(int k);
      logic [63:0] qn;
      logic [63:0] p, c, v;
      qn = 64'(q_noise) << 8;
      p = cov_p[k];
      c = cov_c[k];
      v = cov_v[k];
      st[k]    = clip24(st[k] + st[k+2]);
      cov_p[k] = clip_cov(p + 2 * c + v + qn);
      cov_c[k] = clip_cov(c + v);
      cov_v[k] = clip_cov(v + qn);
   endfunction

   function void correct_axis(int k, longint z);
      logic [63:0] rn, p, c, v, s, mag, t;
      longint      innov, dp, dv;
      rn = 64'(r_noise) << 8;
      p = cov_p[k];
      c = cov_c[k];
      v = cov_v[k];
      s = p + rn;
      innov = z - st[k];
      mag = (innov < 0) ? -innov : innov;
      if (s == 0) return;
      dp = scaled_ratio(p, mag, s);
      dv = scaled_ratio(c, mag, s);
      if (innov < 0) begin
         dp = -dp;
         dv = -dv;
      end
      st[k]   = clip24(st[k] + dp);
      st[k+2] = clip24(st[k+2] + dv);
      t = scaled_ratio(c, c, s);
      cov_p[k] = scaled_ratio(p, rn, s);
      cov_c[k] = scaled_ratio(c, rn, s);
      cov_v[k] = (v > t) ? v - t : 0;
   endfunction

   function void note_frame(logic found, logic [11:0] lft, logic [11:0] top,
                            logic [11:0] rgt, logic [11:0] bot);
      longint           z[2];
      frame_result_type r;
      r.px = 0; r.py = 0; r.qx = 0; r.qy = 0;
      z[0] = (longint'(lft) + longint'(rgt)) << 7;
      z[1] = (longint'(top) + longint'(bot)) << 7;
      if (trk_mode == MODE_ARMED) begin
         if (found) begin
            for (int k = 0; k < 2; k++) begin
               st[k]   = z[k];
               st[k+2] = clip24(z[k] - prev_cen[k]);
               cov_p[k] = 64'(p_init) << 8;
               cov_c[k] = 0;
               cov_v[k] = 64'(p_init) << 8;
            end
            misses = 0;
            trk_mode = MODE_TRACK;
            r.px = 24'(z[0]); r.qx = 24'(z[0]);
            r.py = 24'(z[1]); r.qy = 24'(z[1]);
         end else begin
            trk_mode = MODE_SEARCH;
         end
         r.mode = trk_mode;
      end else if (trk_mode == MODE_TRACK) begin
         for (int k = 0; k < 2; k++) predict_axis(k);
         r.px = 24'(st[0]);
         r.py = 24'(st[1]);
         if (found) begin
            misses = 0;
            for (int k = 0; k < 2; k++) correct_axis(k, z[k]);
         end else if (misses < 15) begin
            misses++;
         end
         r.qx = 24'(st[0]);
         r.qy = 24'(st[1]);
         r.mode = MODE_TRACK;
         if (misses >= miss_lim) begin
            trk_mode = MODE_SEARCH;
            misses = 0;
            r.mode = MODE_LOST;
         end
      end else begin
         trk_mode = MODE_SEARCH;
         if (found) begin
            prev_cen[0] = z[0];
            prev_cen[1] = z[1];
            trk_mode = MODE_ARMED;
         end
         r.mode = trk_mode;
      end
      pending = {pending, r};
   endfunction

   function void check_result(logic [1:0] mode, logic [95:0] data);
      frame_result_type e;
      if (pending.size() == 0) begin
         $error("result transfer with nothing expected");
         fails++;
         return;
      end
      e = pending.pop_front();
      if (mode !== e.mode) begin
         $error("mode expected %0d actual %0d", e.mode, mode);
         fails++;
      end
      if (data[23:0] !== e.px) begin
         $error("pred_x expected %h actual %h", e.px, data[23:0]);
         fails++;
      end
      if (data[47:24] !== e.py) begin
         $error("pred_y expected %h actual %h", e.py, data[47:24]);
         fails++;
      end
      if (data[71:48] !== e.qx) begin
         $error("post_x expected %h actual %h", e.qx, data[71:48]);
         fails++;
      end
      if (data[95:72] !== e.qy) begin
         $error("post_y expected %h actual %h", e.qy, data[95:72]);
         fails++;
      end
   endfunction
endclass

module tb;
   import kts_pkg::*;

   localparam int IDLE_LIMIT = 30000;
   localparam int HOLD_CYCLES = 3000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_addr;
   logic [15:0] csr_data;

   track_scoreboard sb;
   int          burst_left;
   int          frames_sent;
   int          idle_cycles;
   bit          held_once;
   int          cx, cy;

   kalman_track_step_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_addr(csr_addr), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   // watchdog on cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int pat, span;
      rsp_tready = 0;
      pat = 0;
      span = 0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!held_once && frames_sent >= 300) begin
            held_once = 1;
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (span == 0) begin
               pat = $urandom_range(0, 3);
               span = $urandom_range(20, 300);
            end
            span--;
            case (pat)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= ($urandom_range(0, 7) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_frame(logic found, logic [11:0] l, logic [11:0] t,
                             logic [11:0] r, logic [11:0] b);
      if (burst_left == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 25)) @(negedge clock);
         burst_left = $urandom_range(1, 8);
      end
      req_tvalid <= 1;
      req_tuser  <= found;
      req_tdata  <= {b, r, t, l};
      do @(posedge clock); while (!req_tready);
      sb.note_frame(found, l, t, r, b);
      frames_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   // stop offering and let the block drain before a register write
   task automatic drain();
      req_tvalid <= 0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_addr  <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic set_regs(logic [15:0] q, logic [15:0] r, logic [15:0] p0,
                           logic [3:0] lim);
      drain();
      write_csr(CSR_PROCESS_NOISE, q);
      write_csr(CSR_MEASURE_NOISE, r);
      write_csr(CSR_INITIAL_COV, p0);
      write_csr(CSR_MISS_LIMIT, {12'd0, lim});
   endtask

   function automatic logic [11:0] near_coord(int c, int spread);
      int v;
      v = c + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return 12'(v);
   endfunction

   task automatic near_box(logic found);
      int w, h;
      logic [11:0] l, t;
      cx = near_coord(cx, 40);
      cy = near_coord(cy, 40);
      w = $urandom_range(4, 200);
      h = $urandom_range(4, 200);
      l = near_coord(cx - w / 2, 3);
      t = near_coord(cy - h / 2, 3);
      send_frame(found, l, t, near_coord(l + w, 0), near_coord(t + h, 0));
   endtask

   task automatic wild_frame(logic found);
      send_frame(found, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
   endtask

   // search hit, arm hit, then a run of tracking frames with some misses; or search hit, arm miss
   task automatic track_episode(int frames, int miss_pct);
      cx = $urandom_range(0, 4095);
      cy = $urandom_range(0, 4095);
      near_box(1);
      if ($urandom_range(0, 9) == 0) near_box(0);
      else begin
         near_box(1);
         for (int i = 0; i < frames; i++) begin
            if ($urandom_range(0, 99) < miss_pct) near_box(0);
            else near_box(1);
         end
      end
   endtask

   initial begin
      int phase;
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      csr_valid = 0;
      csr_addr = 0;
      csr_data = 0;
      burst_left = 0;
      frames_sent = 0;
      idle_cycles = 0;
      held_once = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      @(negedge clock);

      // directed: reset settings, extremes, armed miss, reversed edges, loss
      send_frame(0, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_frame(1, 0, 0, 0, 0);
      send_frame(0, 0, 0, 0, 0);
      send_frame(1, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_frame(1, 0, 0, 0, 0);
      send_frame(1, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_frame(1, 12'hfff, 0, 0, 12'hfff);
      send_frame(0, 12'h555, 12'haaa, 12'h555, 12'haaa);
      send_frame(1, 100, 200, 50, 150);
      send_frame(0, 0, 0, 0, 0);
      send_frame(0, 0, 0, 0, 0);
      send_frame(0, 0, 0, 0, 0);
      send_frame(0, 0, 0, 0, 0);
      // zero innovation variance and a limit of one
      set_regs(0, 0, 0, 1);
      send_frame(1, 10, 10, 20, 20);
      send_frame(1, 30, 30, 40, 40);
      send_frame(1, 4000, 4000, 4095, 4095);
      send_frame(1, 0, 0, 1, 1);
      send_frame(0, 0, 0, 1, 1);
      set_regs(16'hffff, 16'hffff, 16'hffff, 4'hf);
      send_frame(1, 0, 0, 0, 0);
      send_frame(1, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      for (int i = 0; i < 17; i++) send_frame(0, 0, 0, 0, 0);

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: set_regs(25, 25, 25, 3);
            1: set_regs(0, 0, 0, 1);
            2: set_regs(16'hffff, 16'hffff, 16'hffff, 4'hf);
            3: set_regs(0, 16'hffff, 16'hffff, 2);
            4: set_regs(16'hffff, 0, 0, 1);
            default: set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 300)),
                              16'($urandom_range(0, 65535)), 4'($urandom_range(1, 15)));
         endcase
         while (frames_sent < 40 + (phase + 1) * 180) begin
            if ($urandom_range(0, 9) == 0) wild_frame(1'($urandom_range(0, 1)));
            else track_episode($urandom_range(1, 30), $urandom_range(5, 40));
         end
      end

      drain();
      if (sb.fails == 0) $display("tb passed");
      else $display("tb failed");
      $finish;
   end
endmodule

`default_nettype wire
